// File: src/lso_pkg.sv
// Shared types, constants and the observer microprogram for the state observer.
package lso_pkg;

   localparam int DEF_N_STATES  = 4;
   localparam int DEF_N_INPUTS  = 2;
   localparam int DEF_N_OUTPUTS = 2;
   localparam int DEF_FRAC_BITS = 16;

   localparam int DATA_W   = 32;
   localparam int ACC_W    = 64;
   localparam int N_EST    = 4;
   localparam int STEP_W   = 3;
   localparam int UCODE_DEPTH = 8;

   // Item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // Targets of a write item.
   localparam logic [2:0] SEL_A     = 3'd0;
   localparam logic [2:0] SEL_B     = 3'd1;
   localparam logic [2:0] SEL_C     = 3'd2;
   localparam logic [2:0] SEL_K     = 3'd3;
   localparam logic [2:0] SEL_STATE = 3'd4;

   typedef enum logic [2:0] {
      UOP_MAC_C,
      UOP_MAC_A,
      UOP_MAC_B,
      UOP_MAC_K,
      UOP_DRAIN,
      UOP_COMMIT
   } uop_type;

   typedef struct packed {
      uop_type           op;
      logic              acc_first;
      logic              acc_last;
      logic              row_end;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic    busy;
      logic    issue;
      logic    first;
      logic    last;
      logic    commit;
      uop_type op;
   } seq_ctl_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // Error rows C*x first, then one row of A*x + B*u + K*e per state element.
   localparam ucode_word_type UCODE [UCODE_DEPTH] = '{
      '{op: UOP_MAC_C,  acc_first: 1'b1, acc_last: 1'b1, row_end: 1'b1, target: 3'd0},
      '{op: UOP_DRAIN,  acc_first: 1'b0, acc_last: 1'b0, row_end: 1'b0, target: 3'd0},
      '{op: UOP_MAC_A,  acc_first: 1'b1, acc_last: 1'b0, row_end: 1'b0, target: 3'd0},
      '{op: UOP_MAC_B,  acc_first: 1'b0, acc_last: 1'b0, row_end: 1'b0, target: 3'd0},
      '{op: UOP_MAC_K,  acc_first: 1'b0, acc_last: 1'b1, row_end: 1'b1, target: 3'd2},
      '{op: UOP_DRAIN,  acc_first: 1'b0, acc_last: 1'b0, row_end: 1'b0, target: 3'd0},
      '{op: UOP_COMMIT, acc_first: 1'b0, acc_last: 1'b0, row_end: 1'b0, target: 3'd0},
      '{op: UOP_COMMIT, acc_first: 1'b0, acc_last: 1'b0, row_end: 1'b0, target: 3'd0}
   };

endpackage

// File: src/lso_if.sv
// Handshake channels for observer request and response items.
interface lso_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [2:0]         matrix_select;
   logic [1:0]         row_index;
   logic [1:0]         column_index;
   logic signed [31:0] write_value;
   logic signed [31:0] plant_input_0;
   logic signed [31:0] plant_input_1;
   logic signed [31:0] measured_0;
   logic signed [31:0] measured_1;

   modport source (
      output valid, mode, matrix_select, row_index, column_index, write_value,
             plant_input_0, plant_input_1, measured_0, measured_1,
      input  ready
   );
   modport sink (
      input  valid, mode, matrix_select, row_index, column_index, write_value,
             plant_input_0, plant_input_1, measured_0, measured_1,
      output ready
   );
endinterface

interface lso_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] estimate_0;
   logic signed [31:0] estimate_1;
   logic signed [31:0] estimate_2;
   logic signed [31:0] estimate_3;
   logic               saturated;

   modport source (
      output valid, estimate_0, estimate_1, estimate_2, estimate_3, saturated,
      input  ready
   );
   modport sink (
      input  valid, estimate_0, estimate_1, estimate_2, estimate_3, saturated,
      output ready
   );
endinterface

// File: src/lso_mac.sv
// Pipelined multiply and saturating 64-bit accumulate unit.
module lso_mac #(
   parameter int TAG_W = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lso_pkg::mac_ctl_type              ctl,
   input  logic signed [lso_pkg::DATA_W-1:0] coef,
   input  logic signed [lso_pkg::DATA_W-1:0] opnd,
   input  logic [TAG_W-1:0]                  tag,
   output logic                              busy,
   output logic                              done,
   output logic                              clip,
   output logic signed [lso_pkg::ACC_W-1:0]  acc,
   output logic [TAG_W-1:0]                  acc_tag
);

   localparam logic signed [lso_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(lso_pkg::ACC_W-1){1'b1}}};
   localparam logic signed [lso_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(lso_pkg::ACC_W-1){1'b0}}};

   lso_pkg::mac_ctl_type               prod_ctl_ff;
   logic [TAG_W-1:0]                   prod_tag_ff;
   logic signed [lso_pkg::ACC_W-1:0]   prod_ff;
   logic signed [lso_pkg::ACC_W-1:0]   prod_in;
   logic signed [lso_pkg::ACC_W:0]     sum_wide;
   logic                               ovf;
   logic signed [lso_pkg::ACC_W-1:0]   acc_ff;
   logic signed [lso_pkg::ACC_W-1:0]   acc_in;
   logic                               done_ff;
   logic                               clip_ff;
   logic [TAG_W-1:0]                   acc_tag_ff;

   assign prod_in  = coef * opnd;
   assign sum_wide = {acc_ff[lso_pkg::ACC_W-1], acc_ff} + {prod_ff[lso_pkg::ACC_W-1], prod_ff};
   assign ovf      = sum_wide[lso_pkg::ACC_W] ^ sum_wide[lso_pkg::ACC_W-1];

   always_comb begin
      if (prod_ctl_ff.first) begin
         acc_in = prod_ff;
      end else if (ovf) begin
         acc_in = sum_wide[lso_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = sum_wide[lso_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         done_ff     <= 1'b0;
         clip_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= ctl;
         done_ff     <= prod_ctl_ff.valid & prod_ctl_ff.last;
         clip_ff     <= prod_ctl_ff.valid & ~prod_ctl_ff.first & ovf;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_tag_ff <= tag;
      if (prod_ctl_ff.valid) begin
         acc_ff     <= acc_in;
         acc_tag_ff <= prod_tag_ff;
      end
   end

   assign busy    = prod_ctl_ff.valid | done_ff;
   assign done    = done_ff;
   assign clip    = clip_ff;
   assign acc     = acc_ff;
   assign acc_tag = acc_tag_ff;

endmodule

// File: src/lso_seq.sv
// Microcode sequencer that walks the observer program over row and column counters.
module lso_seq #(
   parameter int N_STATES  = lso_pkg::DEF_N_STATES,
   parameter int N_INPUTS  = lso_pkg::DEF_N_INPUTS,
   parameter int N_OUTPUTS = lso_pkg::DEF_N_OUTPUTS,
   parameter int CW        = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 drain_busy,
   input  logic                 out_hold,
   output lso_pkg::seq_ctl_type ctl,
   output logic [CW-1:0]        row,
   output logic [CW-1:0]        col
);

   logic                       busy_ff, busy_in;
   logic [lso_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]              i_ff, i_in;
   logic [CW-1:0]              j_ff, j_in;
   lso_pkg::ucode_word_type    word;
   logic                       is_mac;
   logic [CW-1:0]              j_lim;
   logic [CW-1:0]              i_lim;
   logic                       j_last;
   logic                       i_last;

   assign word   = lso_pkg::UCODE[step_ff];
   assign is_mac = word.op inside {lso_pkg::UOP_MAC_C, lso_pkg::UOP_MAC_A,
                                   lso_pkg::UOP_MAC_B, lso_pkg::UOP_MAC_K};

   always_comb begin
      case (word.op)
         lso_pkg::UOP_MAC_B: j_lim = CW'(N_INPUTS - 1);
         lso_pkg::UOP_MAC_K: j_lim = CW'(N_OUTPUTS - 1);
         default:            j_lim = CW'(N_STATES - 1);
      endcase
      i_lim = (word.op == lso_pkg::UOP_MAC_C) ? CW'(N_OUTPUTS - 1) : CW'(N_STATES - 1);
   end

   assign j_last = (j_ff == j_lim);
   assign i_last = (i_ff == i_lim);

   // Next step, counters and busy flag.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
            i_in    = '0;
            j_in    = '0;
         end
      end else if (is_mac) begin
         if (!j_last) begin
            j_in = j_ff + 1'b1;
         end else begin
            j_in = '0;
            if (!word.row_end) begin
               step_in = step_ff + 1'b1;
            end else if (i_last) begin
               i_in    = '0;
               step_in = step_ff + 1'b1;
            end else begin
               i_in    = i_ff + 1'b1;
               step_in = word.target;
            end
         end
      end else begin
         case (word.op)
            lso_pkg::UOP_DRAIN: begin
               if (!drain_busy) begin
                  step_in = step_ff + 1'b1;
               end
            end
            lso_pkg::UOP_COMMIT: begin
               if (!out_hold) begin
                  busy_in = 1'b0;
                  step_in = '0;
               end
            end
            default: begin
               busy_in = 1'b0;
               step_in = '0;
            end
         endcase
      end
   end

   // Control word decode toward the datapath.
   always_comb begin
      ctl.busy   = busy_ff;
      ctl.op     = word.op;
      ctl.issue  = busy_ff & is_mac;
      ctl.first  = word.acc_first & (j_ff == '0);
      ctl.last   = word.acc_last & j_last;
      ctl.commit = busy_ff & (word.op == lso_pkg::UOP_COMMIT) & ~out_hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   assign row = i_ff;
   assign col = j_ff;

endmodule

// File: src/luenberger_state_observer_top.sv
// Discrete Luenberger state observer in signed fixed point, run by a small microprogram.
// A write item (mode 0) loads one coefficient of A, B, C or K, or one element of the state
// estimate, and returns nothing. A step item (mode 1) computes the error e = y - C*x and then
// x' = A*x + B*u + K*e on a single shared 32x32 multiplier with a saturating 64-bit
// accumulator, and returns the new estimate with a flag that is set when any sum, error or
// state value was clipped. One step issues one multiply-accumulate per cycle while it runs its
// error rows and then its state rows, and drains the pipeline after each of the two groups
// before it commits; the commit waits while an earlier result is still held. The result is
// offered once the step commits, and the next item can be taken in that same cycle; the shared
// multiplier and the single read port of the coefficient memory make the multiplies run one
// after another. New items are taken only while no step is in progress; a finished result
// waits in an output register.
module luenberger_state_observer_top #(
   parameter int N_STATES  = lso_pkg::DEF_N_STATES,
   parameter int N_INPUTS  = lso_pkg::DEF_N_INPUTS,
   parameter int N_OUTPUTS = lso_pkg::DEF_N_OUTPUTS,
   parameter int FRAC_BITS = lso_pkg::DEF_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   lso_req_if.sink   req_ch,
   lso_rsp_if.source rsp_ch
);

   localparam int OFS_B = N_STATES * N_STATES;
   localparam int OFS_C = OFS_B + N_STATES * N_INPUTS;
   localparam int OFS_K = OFS_C + N_OUTPUTS * N_STATES;
   localparam int DEPTH = OFS_K + N_STATES * N_OUTPUTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (N_STATES > 1) ? $clog2(N_STATES) : 1;
   localparam int IW    = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int OW    = (N_OUTPUTS > 1) ? $clog2(N_OUTPUTS) : 1;
   localparam int MAXIO = (N_INPUTS > N_OUTPUTS) ? N_INPUTS : N_OUTPUTS;
   localparam int MAXD  = (N_STATES > MAXIO) ? N_STATES : MAXIO;
   localparam int CW    = (MAXD > 1) ? $clog2(MAXD) : 1;
   localparam int TAG_W = CW + 1;
   localparam int DW    = lso_pkg::DATA_W;
   localparam int ACCW  = lso_pkg::ACC_W;
   localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

   logic signed [DW-1:0] coef_mem [DEPTH];
   logic signed [DW-1:0] x_ff  [N_STATES];
   logic signed [DW-1:0] nx_ff [N_STATES];
   logic signed [DW-1:0] e_ff  [N_OUTPUTS];
   logic signed [DW-1:0] y_ff  [N_OUTPUTS];
   logic signed [DW-1:0] u_ff  [N_INPUTS];

   lso_pkg::seq_ctl_type seq_ctl;
   logic [CW-1:0]        seq_row;
   logic [CW-1:0]        seq_col;

   logic                 req_fire;
   logic                 wr_fire;
   logic                 step_fire;
   logic                 wr_coef;
   logic                 wr_state;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic signed [DW-1:0] opnd_in;

   logic signed [DW-1:0] coef_rd_ff;
   logic signed [DW-1:0] opnd_ff;
   lso_pkg::mac_ctl_type p1_ctl_ff, p1_ctl_in;
   logic [TAG_W-1:0]     p1_tag_ff;

   logic                 mac_busy;
   logic                 mac_done;
   logic                 mac_clip;
   logic signed [ACCW-1:0] mac_acc;
   logic [TAG_W-1:0]     mac_tag;

   logic signed [ACCW-1:0] acc_shr;
   logic                 shr_fits;
   logic signed [DW-1:0] row_val;
   logic signed [DW:0]   err_wide;
   logic                 err_fits;
   logic signed [DW-1:0] err_val;
   logic                 fin_is_c;
   logic [CW-1:0]        fin_row;
   logic                 fin_clip;

   logic                 clip_ff, clip_in;
   logic                 out_hold;
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] est_ff [lso_pkg::N_EST];
   logic                 sat_ff;

   assign req_ch.ready = ~seq_ctl.busy;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign wr_fire      = req_fire & (req_ch.mode == lso_pkg::MODE_WRITE);
   assign step_fire    = req_fire & (req_ch.mode == lso_pkg::MODE_STEP);
   assign out_hold     = rsp_valid_ff & ~rsp_ch.ready;

   // Write item decode: a target outside the selected matrix or vector is dropped.
   always_comb begin
      wr_coef  = 1'b0;
      wr_state = 1'b0;
      wr_addr  = '0;
      case (req_ch.matrix_select)
         lso_pkg::SEL_A: begin
            wr_coef = (int'(req_ch.row_index) < N_STATES) &&
                      (int'(req_ch.column_index) < N_STATES);
            wr_addr = AW'(int'(req_ch.row_index) * N_STATES + int'(req_ch.column_index));
         end
         lso_pkg::SEL_B: begin
            wr_coef = (int'(req_ch.row_index) < N_STATES) &&
                      (int'(req_ch.column_index) < N_INPUTS);
            wr_addr = AW'(OFS_B + int'(req_ch.row_index) * N_INPUTS
                          + int'(req_ch.column_index));
         end
         lso_pkg::SEL_C: begin
            wr_coef = (int'(req_ch.row_index) < N_OUTPUTS) &&
                      (int'(req_ch.column_index) < N_STATES);
            wr_addr = AW'(OFS_C + int'(req_ch.row_index) * N_STATES
                          + int'(req_ch.column_index));
         end
         lso_pkg::SEL_K: begin
            wr_coef = (int'(req_ch.row_index) < N_STATES) &&
                      (int'(req_ch.column_index) < N_OUTPUTS);
            wr_addr = AW'(OFS_K + int'(req_ch.row_index) * N_OUTPUTS
                          + int'(req_ch.column_index));
         end
         lso_pkg::SEL_STATE: begin
            wr_state = int'(req_ch.row_index) < N_STATES;
         end
         default: begin
            wr_coef  = 1'b0;
            wr_state = 1'b0;
         end
      endcase
   end

   lso_seq #(
      .N_STATES  (N_STATES),
      .N_INPUTS  (N_INPUTS),
      .N_OUTPUTS (N_OUTPUTS),
      .CW        (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (step_fire),
      .drain_busy (p1_ctl_ff.valid | mac_busy),
      .out_hold   (out_hold),
      .ctl        (seq_ctl),
      .row        (seq_row),
      .col        (seq_col)
   );

   // Coefficient address and vector operand for the issued multiply.
   always_comb begin
      case (seq_ctl.op)
         lso_pkg::UOP_MAC_C: begin
            rd_addr = AW'(OFS_C + int'(seq_row) * N_STATES + int'(seq_col));
            opnd_in = x_ff[seq_col[SW-1:0]];
         end
         lso_pkg::UOP_MAC_B: begin
            rd_addr = AW'(OFS_B + int'(seq_row) * N_INPUTS + int'(seq_col));
            opnd_in = u_ff[seq_col[IW-1:0]];
         end
         lso_pkg::UOP_MAC_K: begin
            rd_addr = AW'(OFS_K + int'(seq_row) * N_OUTPUTS + int'(seq_col));
            opnd_in = e_ff[seq_col[OW-1:0]];
         end
         default: begin
            rd_addr = AW'(int'(seq_row) * N_STATES + int'(seq_col));
            opnd_in = x_ff[seq_col[SW-1:0]];
         end
      endcase
      p1_ctl_in.valid = seq_ctl.issue;
      p1_ctl_in.first = seq_ctl.first;
      p1_ctl_in.last  = seq_ctl.last;
   end

   always_ff @(posedge clock) begin
      if (wr_fire && wr_coef) begin
         coef_mem[wr_addr] <= req_ch.write_value;
      end
      if (seq_ctl.issue) begin
         coef_rd_ff <= coef_mem[rd_addr];
         opnd_ff    <= opnd_in;
         p1_tag_ff  <= {seq_ctl.op == lso_pkg::UOP_MAC_C, seq_row};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff <= '0;
      end else begin
         p1_ctl_ff <= p1_ctl_in;
      end
   end

   lso_mac #(
      .TAG_W (TAG_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (p1_ctl_ff),
      .coef    (coef_rd_ff),
      .opnd    (opnd_ff),
      .tag     (p1_tag_ff),
      .busy    (mac_busy),
      .done    (mac_done),
      .clip    (mac_clip),
      .acc     (mac_acc),
      .acc_tag (mac_tag)
   );

   // Finish a row: scale down, clip to 32 bits, and for error rows subtract from y.
   assign fin_is_c = mac_tag[TAG_W-1];
   assign fin_row  = mac_tag[CW-1:0];
   assign acc_shr  = mac_acc >>> FRAC_BITS;
   assign shr_fits = (&acc_shr[ACCW-1:DW-1]) | ~(|acc_shr[ACCW-1:DW-1]);

   always_comb begin
      if (shr_fits) begin
         row_val = acc_shr[DW-1:0];
      end else begin
         row_val = acc_shr[ACCW-1] ? Q_MIN : Q_MAX;
      end
      err_wide = {y_ff[fin_row[OW-1:0]][DW-1], y_ff[fin_row[OW-1:0]]}
                 - {row_val[DW-1], row_val};
      err_fits = ~(err_wide[DW] ^ err_wide[DW-1]);
      if (err_fits) begin
         err_val = err_wide[DW-1:0];
      end else begin
         err_val = err_wide[DW] ? Q_MIN : Q_MAX;
      end
      fin_clip = mac_done & (~shr_fits | (fin_is_c & ~err_fits));
      clip_in  = step_fire ? 1'b0 : (clip_ff | mac_clip | fin_clip);
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         for (int k = 0; k < N_INPUTS; k++) begin
            if (k == 0) begin
               u_ff[k] <= req_ch.plant_input_0;
            end else if (k == 1) begin
               u_ff[k] <= req_ch.plant_input_1;
            end else begin
               u_ff[k] <= '0;
            end
         end
         for (int k = 0; k < N_OUTPUTS; k++) begin
            if (k == 0) begin
               y_ff[k] <= req_ch.measured_0;
            end else if (k == 1) begin
               y_ff[k] <= req_ch.measured_1;
            end else begin
               y_ff[k] <= '0;
            end
         end
      end
      if (mac_done) begin
         if (fin_is_c) begin
            e_ff[fin_row[OW-1:0]] <= err_val;
         end else begin
            nx_ff[fin_row[SW-1:0]] <= row_val;
         end
      end
   end

   // State estimate, response register and clip flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_STATES; k++) begin
            x_ff[k] <= '0;
         end
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clip_ff <= clip_in;
         if (wr_fire && wr_state) begin
            x_ff[SW'(req_ch.row_index)] <= req_ch.write_value;
         end
         if (seq_ctl.commit) begin
            for (int k = 0; k < N_STATES; k++) begin
               x_ff[k] <= nx_ff[k];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctl.commit) begin
         for (int k = 0; k < lso_pkg::N_EST; k++) begin
            est_ff[k] <= (k < N_STATES) ? nx_ff[k % N_STATES] : '0;
         end
         sat_ff <= clip_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.estimate_0 = est_ff[0];
   assign rsp_ch.estimate_1 = est_ff[1];
   assign rsp_ch.estimate_2 = est_ff[2];
   assign rsp_ch.estimate_3 = est_ff[3];
   assign rsp_ch.saturated  = sat_ff;

endmodule
